### rtl/core/btsp_pkg.sv
// Package for the TLV stream parser: phase, event and error codes, config indexes.
// No dependencies.
package btsp_pkg;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_TAG   = 3'd1,
        PH_LEN1  = 3'd2,
        PH_LENX  = 3'd3,
        PH_VALUE = 3'd4,
        PH_ERR   = 3'd5
    } phase_t;

    localparam logic [2:0] EV_HEADER = 3'd0;
    localparam logic [2:0] EV_PAD    = 3'd1;
    localparam logic [2:0] EV_DONE   = 3'd2;
    localparam logic [2:0] EV_VALUE  = 3'd3;
    localparam logic [2:0] EV_ERROR  = 3'd4;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_INVALID = 3'd1;
    localparam logic [2:0] ERR_LIMIT   = 3'd2;
    localparam logic [2:0] ERR_TRUNC   = 3'd3;
    localparam logic [2:0] ERR_UNSUP   = 3'd4;

    localparam logic [2:0] PROF_DER  = 3'd0;
    localparam logic [2:0] PROF_BER  = 3'd1;
    localparam logic [2:0] PROF_ISO  = 3'd2;
    localparam logic [2:0] PROF_ISOZ = 3'd3;
    localparam logic [2:0] PROF_ISOF = 3'd4;

    localparam logic [1:0] CFG_PROFILE  = 2'd0;
    localparam logic [1:0] CFG_MAX_VAL  = 2'd1;
    localparam logic [1:0] CFG_MAX_ELEM = 2'd2;
    localparam logic [1:0] CFG_MAX_IN   = 2'd3;

    // one result beat
    typedef struct packed {
        logic [2:0]  event_res;
        logic [2:0]  error_code;
        logic [1:0]  tclass;
        logic        constructed;
        logic [31:0] tag_number;
        logic [2:0]  tag_len;
        logic [3:0]  hdr_len;
        logic [31:0] value_length;
        logic [31:0] element_index;
        logic        element_end;
        logic        stream_end;
    } result_t;

endpackage

### rtl/core/ber_tlv_stream_parser_unit.sv
// Top level of the TLV stream parser: config registers, parse state, output register.
// Depends on btsp_pkg.
//
//  channel | signals                                  | direction
//  input   | in_valid, in_ready, data_byte, last_byte | in
//  output  | out_valid, out_ready, result fields      | out
//  config  | cfg_we, cfg_index, cfg_data              | in
//
// One byte per cycle unless out_ready stalls; each byte yields one registered result beat.
// The parse step is one combinational pass from state and byte into the result register.
// Reset clears the stream state and sets the limits to all ones, profile to DER.
// A new byte is taken while the output register is empty or its beat is being taken.
module ber_tlv_stream_parser_unit #(
    parameter int TAG_BYTES = 4,
    parameter int LEN_BYTES = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  event_res,
    output logic [2:0]  error_code,
    output logic [1:0]  tclass,
    output logic        constructed,
    output logic [31:0] tag_number,
    output logic [2:0]  tag_len,
    output logic [3:0]  hdr_len,
    output logic [31:0] value_length,
    output logic [31:0] element_index,
    output logic        element_end,
    output logic        stream_end,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import btsp_pkg::*;

    localparam logic [2:0] TagMax = 3'(TAG_BYTES);
    localparam logic [6:0] LenMax = 7'(LEN_BYTES);

    logic [2:0]  profile_reg;
    logic [31:0] max_vlen_reg, max_elements_reg, max_input_reg;

    phase_t      phase_reg, phase_next;
    logic [31:0] tag_reg, tag_next;
    logic [2:0]  tcnt_reg, tcnt_next;
    logic [2:0]  cc_reg, cc_next;
    logic [3:0]  lleft_reg, lleft_next;
    logic [31:0] lacc_reg, lacc_next;
    logic [31:0] vrem_reg, vrem_next;
    logic [3:0]  hcnt_reg, hcnt_next;
    logic [31:0] icnt_reg, icnt_next;
    logic [31:0] ecnt_reg, ecnt_next;
    logic [2:0]  sticky_reg, sticky_next;

    result_t     res_reg, res_next;
    logic        ovalid_reg;
    logic        take;

    assign in_ready = !ovalid_reg || out_ready;
    assign take     = in_valid && in_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            profile_reg      <= PROF_DER;
            max_vlen_reg     <= '1;
            max_elements_reg <= '1;
            max_input_reg    <= '1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PROFILE:  profile_reg      <= cfg_data[2:0];
                CFG_MAX_VAL:  max_vlen_reg     <= cfg_data;
                CFG_MAX_ELEM: max_elements_reg <= cfg_data;
                CFG_MAX_IN:   max_input_reg    <= cfg_data;
                default:      profile_reg      <= profile_reg;
            endcase
        end
    end

    // parse step
    always_comb
    begin
        logic        iso, pad, finish, hdr, el_end, s_end;
        logic [2:0]  ev, err;
        logic [6:0]  low;
        logic [4:0]  num;
        logic [38:0] tag_wide;
        logic [39:0] len_wide;
        logic [31:0] vdec;

        phase_next  = phase_reg;
        tag_next    = tag_reg;
        tcnt_next   = tcnt_reg;
        cc_next     = cc_reg;
        lleft_next  = lleft_reg;
        lacc_next   = lacc_reg;
        vrem_next   = vrem_reg;
        hcnt_next   = hcnt_reg;
        icnt_next   = icnt_reg;
        ecnt_next   = ecnt_reg;
        sticky_next = sticky_reg;

        iso    = (profile_reg == PROF_ISO) || (profile_reg == PROF_ISOZ)
                 || (profile_reg == PROF_ISOF);
        pad    = (((profile_reg == PROF_ISOZ) || (profile_reg == PROF_ISOF))
                  && data_byte == 8'h00) || (profile_reg == PROF_ISOF && data_byte == 8'hff);
        ev     = EV_HEADER;
        err    = ERR_NONE;
        finish = 1'b0;
        hdr    = 1'b0;
        el_end = 1'b0;
        s_end  = 1'b0;
        low    = data_byte[6:0];
        num    = data_byte[4:0];
        tag_wide = {tag_reg, low};
        len_wide = {lacc_reg, data_byte};
        vdec   = vrem_reg - 32'd1;

        if (phase_reg == PH_ERR)
        begin
            err = sticky_reg;
        end
        else if (profile_reg > PROF_ISOF)
        begin
            err = ERR_UNSUP;
        end
        else if (icnt_reg >= max_input_reg)
        begin
            err = ERR_LIMIT;
        end
        else
        begin
            icnt_next = icnt_reg + 32'd1;
            case (phase_reg)
                PH_IDLE:
                begin
                    if (pad)
                        ev = EV_PAD;
                    else if (ecnt_reg >= max_elements_reg)
                        err = ERR_LIMIT;
                    else if (data_byte == 8'h00 || (iso && data_byte == 8'hff))
                        err = ERR_INVALID;
                    else
                    begin
                        cc_next   = data_byte[7:5];
                        tcnt_next = 3'd1;
                        hcnt_next = 4'd1;
                        if (num == 5'd31)
                        begin
                            tag_next   = '0;
                            phase_next = PH_TAG;
                        end
                        else if (data_byte[7:6] == 2'd0 && num == 5'd0)
                            err = ERR_INVALID;
                        else
                        begin
                            tag_next   = {27'd0, num};
                            phase_next = PH_LEN1;
                        end
                    end
                end
                PH_TAG:
                begin
                    if (tcnt_reg >= TagMax || (iso && tcnt_reg >= 3'd3))
                        err = ERR_LIMIT;
                    else
                    begin
                        tcnt_next = tcnt_reg + 3'd1;
                        hcnt_next = hcnt_reg + 4'd1;
                        if (tcnt_reg == 3'd1 && low == 7'd0)
                            err = ERR_INVALID;
                        else if (tag_wide[38:32] != 7'd0)
                            err = ERR_LIMIT;
                        else
                        begin
                            tag_next = tag_wide[31:0];
                            if (!data_byte[7])
                            begin
                                if (tag_wide[31:0] < 32'd31)
                                    err = ERR_INVALID;
                                else
                                    phase_next = PH_LEN1;
                            end
                        end
                    end
                end
                PH_LEN1:
                begin
                    hcnt_next = hcnt_reg + 4'd1;
                    if (data_byte == 8'hff)
                        err = ERR_INVALID;
                    else if (data_byte == 8'h80)
                        err = (profile_reg == PROF_BER && cc_reg[0]) ? ERR_UNSUP : ERR_INVALID;
                    else if (data_byte[7])
                    begin
                        if (low > LenMax || (iso && low > 7'd4))
                            err = ERR_LIMIT;
                        else
                        begin
                            lleft_next = low[3:0];
                            lacc_next  = '0;
                            phase_next = PH_LENX;
                        end
                    end
                    else
                    begin
                        lacc_next = {24'd0, data_byte};
                        finish    = 1'b1;
                    end
                end
                PH_LENX:
                begin
                    hcnt_next = hcnt_reg + 4'd1;
                    if (profile_reg == PROF_DER && hcnt_reg == {1'b0, tcnt_reg} + 4'd1
                        && data_byte == 8'h00)
                        err = ERR_INVALID;
                    else if (len_wide[39:32] != 8'd0)
                        err = ERR_LIMIT;
                    else
                    begin
                        lacc_next  = len_wide[31:0];
                        lleft_next = lleft_reg - 4'd1;
                        if (lleft_reg == 4'd1)
                        begin
                            if (profile_reg == PROF_DER && len_wide[31:0] < 32'd128)
                                err = ERR_INVALID;
                            else
                                finish = 1'b1;
                        end
                    end
                end
                default:
                begin
                    ev        = EV_VALUE;
                    vrem_next = vdec;
                    if (vdec == 32'd0)
                    begin
                        el_end     = 1'b1;
                        ecnt_next  = ecnt_reg + 32'd1;
                        phase_next = PH_IDLE;
                    end
                end
            endcase
            if (finish)
            begin
                if (lacc_next > max_vlen_reg)
                    err = ERR_LIMIT;
                else
                begin
                    ev        = EV_DONE;
                    hdr       = 1'b1;
                    vrem_next = lacc_next;
                    if (lacc_next == 32'd0)
                    begin
                        el_end     = 1'b1;
                        ecnt_next  = ecnt_reg + 32'd1;
                        phase_next = PH_IDLE;
                    end
                    else
                        phase_next = PH_VALUE;
                end
            end
            if (err == ERR_NONE && last_byte && phase_next != PH_IDLE)
                err = ERR_TRUNC;
            if (err == ERR_NONE && last_byte)
                s_end = 1'b1;
        end

        if (err != ERR_NONE)
        begin
            ev          = EV_ERROR;
            hdr         = 1'b0;
            el_end      = 1'b0;
            s_end       = 1'b0;
            phase_next  = PH_ERR;
            sticky_next = err;
        end

        res_next.event_res     = ev;
        res_next.error_code    = err;
        res_next.tclass        = hdr ? cc_next[2:1] : 2'd0;
        res_next.constructed   = hdr ? cc_next[0] : 1'b0;
        res_next.tag_number    = hdr ? tag_next : 32'd0;
        res_next.tag_len       = hdr ? tcnt_next : 3'd0;
        res_next.hdr_len       = hdr ? hcnt_next : 4'd0;
        res_next.value_length  = hdr ? lacc_next : 32'd0;
        res_next.element_index = ecnt_reg;
        res_next.element_end   = el_end;
        res_next.stream_end    = s_end;

        // clean restart after the last byte
        if (last_byte)
        begin
            phase_next  = PH_IDLE;
            tag_next    = '0;
            tcnt_next   = '0;
            cc_next     = '0;
            lleft_next  = '0;
            lacc_next   = '0;
            vrem_next   = '0;
            hcnt_next   = '0;
            icnt_next   = '0;
            ecnt_next   = '0;
            sticky_next = ERR_NONE;
        end
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            tag_reg    <= '0;
            tcnt_reg   <= '0;
            cc_reg     <= '0;
            lleft_reg  <= '0;
            lacc_reg   <= '0;
            vrem_reg   <= '0;
            hcnt_reg   <= '0;
            icnt_reg   <= '0;
            ecnt_reg   <= '0;
            sticky_reg <= ERR_NONE;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            tag_reg    <= tag_next;
            tcnt_reg   <= tcnt_next;
            cc_reg     <= cc_next;
            lleft_reg  <= lleft_next;
            lacc_reg   <= lacc_next;
            vrem_reg   <= vrem_next;
            hcnt_reg   <= hcnt_next;
            icnt_reg   <= icnt_next;
            ecnt_reg   <= ecnt_next;
            sticky_reg <= sticky_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (take)
            ovalid_reg <= 1'b1;
        else if (out_ready)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            res_reg <= res_next;
    end

    assign out_valid     = ovalid_reg;
    assign event_res     = res_reg.event_res;
    assign error_code    = res_reg.error_code;
    assign tclass        = res_reg.tclass;
    assign constructed   = res_reg.constructed;
    assign tag_number    = res_reg.tag_number;
    assign tag_len       = res_reg.tag_len;
    assign hdr_len       = res_reg.hdr_len;
    assign value_length  = res_reg.value_length;
    assign element_index = res_reg.element_index;
    assign element_end   = res_reg.element_end;
    assign stream_end    = res_reg.stream_end;

    // checks
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ERR) |-> (sticky_reg != ERR_NONE))
        else $error("error phase without held code");
    a_err_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (error_code != ERR_NONE) |-> (event_res == EV_ERROR) && !stream_end)
        else $error("error beat with wrong event");
    a_end_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && element_end |-> (event_res == EV_DONE || event_res == EV_VALUE))
        else $error("element end on wrong event");
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        take && last_byte |=> (phase_reg == PH_IDLE) && (icnt_reg == 32'd0))
        else $error("no restart after last byte");
endmodule
